// ===== rtl/core/lttf_pkg.sv =====
`timescale 1ns / 1ps

package lttf_pkg;

    // channel and field widths
    localparam int PIX_W      = 8;
    localparam int LANES      = 3;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // stream packing
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - ROW_W - COL_W - LANES * PIX_W;

    // line store word: four rows of three channels
    localparam int SLOTS  = 4;
    localparam int PIXW_W = LANES * PIX_W;
    localparam int LINE_W = SLOTS * PIXW_W;

    // frame limits and reset values
    localparam int MIN_DIM      = 5;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // horizontal sum width before the divide by sixteen
    localparam int HSUM_W = PIX_W + 4;
    // vertical sum width, signed
    localparam int VSUM_W = PIX_W + 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // position flags of one pixel, computed at request time
    typedef struct packed {
        logic             emit;
        logic             last;
        logic             inner;
        logic [ROW_W-1:0] orow;
    } raster_info_t;

endpackage

// ===== rtl/core/lttf_line_store.sv =====
`timescale 1ns / 1ps

module lttf_line_store
    import lttf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = $clog2(MAX_WIDTH)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [LINE_W-1:0] rd_data_reg,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] mem [MAX_WIDTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/lttf_lane.sv =====
`timescale 1ns / 1ps

module lttf_lane
    import lttf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic                   en,
    input  logic [PIX_W-1:0]       pix,
    input  logic                   h_on,
    input  logic [SLOTS*PIX_W-1:0] line,
    input  logic                   inner,
    output logic [PIX_W-1:0]       hval_reg,
    output logic [PIX_W-1:0]       res_reg
);

    logic [PIX_W-1:0]  win_reg [SLOTS];
    logic [HSUM_W-1:0] hsum;
    logic [PIX_W-1:0]  hval_next;
    logic [VSUM_W-1:0] vsum;
    logic [VSUM_W-1:0] mag;
    logic [PIX_W-1:0]  res_next;

    // last four pixels of this channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[SLOTS-1] <= pix;
        end
    end

    // horizontal l5 and divide by sixteen
    always_comb
    begin
        hsum = HSUM_W'(win_reg[0]) + HSUM_W'(win_reg[1]) * HSUM_W'(4)
             + HSUM_W'(win_reg[2]) * HSUM_W'(6) + HSUM_W'(win_reg[3]) * HSUM_W'(4)
             + HSUM_W'(pix);
        hval_next = h_on ? hsum[HSUM_W-1:4] : '0;
    end

    // vertical r5, absolute value and saturation
    always_comb
    begin
        vsum = VSUM_W'(line[0*PIX_W +: PIX_W])
             - VSUM_W'(line[1*PIX_W +: PIX_W]) * VSUM_W'(4)
             + VSUM_W'(line[2*PIX_W +: PIX_W]) * VSUM_W'(6)
             - VSUM_W'(line[3*PIX_W +: PIX_W]) * VSUM_W'(4)
             + VSUM_W'(hval_reg);
        mag = vsum[VSUM_W-1] ? (~vsum + VSUM_W'(1)) : vsum;
        if (!inner)
        begin
            res_next = '0;
        end
        else if (mag > VSUM_W'((1 << PIX_W) - 1))
        begin
            res_next = '1;
        end
        else
        begin
            res_next = mag[PIX_W-1:0];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hval_reg <= hval_next;
            res_reg  <= res_next;
        end
    end

endmodule

// ===== rtl/core/lttf_raster.sv =====
`timescale 1ns / 1ps

module lttf_raster
    import lttf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = $clog2(MAX_WIDTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output raster_info_t          info,
    output logic [CW-1:0]         hc,
    output logic                  h_on
);

    localparam int WW = CW + 1;

    logic [IW_W-1:0]  iw_reg;
    logic [IH_W-1:0]  ih_reg;
    logic [CW-1:0]    c_reg;
    logic [ROW_W-1:0] r_reg;
    logic [IH_W-1:0]  iw_ext;
    logic [WW-1:0]    w_eff;
    logic [IH_W-1:0]  h_eff;
    logic [WW-1:0]    c_p1;
    logic [IH_W-1:0]  r_p1;
    logic             col_wrap;
    logic             row_wrap;
    logic             c_ge2;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= IW_W'(WIDTH_RESET);
            ih_reg <= IH_W'(HEIGHT_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  iw_reg <= cfg_data[IW_W-1:0];
                REG_IMAGE_HEIGHT: ih_reg <= cfg_data[IH_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp frame size
    always_comb
    begin
        iw_ext = IH_W'(iw_reg);
        if (iw_ext < IH_W'(MIN_DIM))
        begin
            w_eff = WW'(MIN_DIM);
        end
        else if (iw_ext > IH_W'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(iw_ext);
        end
        if (ih_reg < IH_W'(MIN_DIM))
        begin
            h_eff = IH_W'(MIN_DIM);
        end
        else if (ih_reg > IH_W'(MAX_HEIGHT))
        begin
            h_eff = IH_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = ih_reg;
        end
    end

    // position of the pixel two rows and two columns behind
    always_comb
    begin
        c_p1     = WW'(c_reg) + WW'(1);
        r_p1     = IH_W'(r_reg) + IH_W'(1);
        col_wrap = c_p1 >= w_eff;
        row_wrap = r_p1 >= h_eff;
        c_ge2    = c_reg >= CW'(2);
        h_on     = c_reg >= CW'(4);
        if (c_ge2)
        begin
            hc = c_reg - CW'(2);
        end
        else
        begin
            hc = CW'(WW'(c_reg) + w_eff - WW'(2));
        end
        info.emit  = (r_reg >= ROW_W'(3)) || ((r_reg == ROW_W'(2)) && c_ge2);
        info.last  = row_wrap && col_wrap;
        info.orow  = c_ge2 ? (r_reg - ROW_W'(2)) : (r_reg - ROW_W'(3));
        info.inner = (info.orow >= ROW_W'(2))
                  && ((IH_W'(info.orow) + IH_W'(3)) <= h_eff)
                  && (hc >= CW'(2))
                  && ((WW'(hc) + WW'(2)) <= (w_eff - WW'(1)));
    end

    // raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
            r_reg <= '0;
        end
        else if (take)
        begin
            if (col_wrap)
            begin
                c_reg <= '0;
                r_reg <= row_wrap ? '0 : r_p1[ROW_W-1:0];
            end
            else
            begin
                c_reg <= c_p1[CW-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/laws_l5r5_texture_filter_unit.sv =====
`timescale 1ns / 1ps

// Laws L5R5 texture filter on an RGB raster stream. One pixel request is taken
// every clock while the output side keeps up; a result passes through stage one
// and the output register and stands for the pixel 2*width+2 positions
// earlier, with zeros in the two border rows and columns. The line store is
// a single memory of MAX_WIDTH words holding four rows of horizontal values,
// read once at request time and written back from stage one.
// The first 2*width+2 pixels of the stream give no result, and the last 2*width+2
// pixels of each frame are never emitted. There is no clearing pass after reset.
// Width and height are clamped to 5..MAX_WIDTH and 5..4096 and must only be
// written while no request is in flight.
module laws_l5r5_texture_filter_unit
    import lttf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // out_row [11:0], out_col [21:12], out_red [29:22], out_green [37:30],
    // out_blue [45:38], zero [47:46]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                    en;
    logic                    take;
    raster_info_t            info;
    logic [CW-1:0]           hc;
    logic                    h_on;
    logic                    s1_valid_reg;
    raster_info_t            s1_info_reg;
    logic [CW-1:0]           s1_hc_reg;
    logic [LINE_W-1:0]       line_rd;
    logic [LINE_W-1:0]       line_wr;
    logic [SLOTS*PIX_W-1:0]  lane_line [LANES];
    logic [PIX_W-1:0]        lane_hval [LANES];
    logic [PIX_W-1:0]        lane_res  [LANES];
    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic [COL_W-1:0]        out_col_reg;

    // pipeline advances whenever the output register is free or drained
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign take          = s_axis_tvalid && en;

    lttf_raster #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .info      (info),
        .hc        (hc),
        .h_on      (h_on)
    );

    lttf_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (CW)
    ) u_line_store (
        .clk         (clk),
        .rd_en       (en),
        .rd_addr     (hc),
        .rd_data_reg (line_rd),
        .wr_en       (en && s1_valid_reg),
        .wr_addr     (s1_hc_reg),
        .wr_data     (line_wr)
    );

    // split line store word per channel and build the shifted write word
    always_comb
    begin
        for (int ch = 0; ch < LANES; ch++)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                lane_line[ch][k*PIX_W +: PIX_W] = line_rd[k*PIXW_W + ch*PIX_W +: PIX_W];
            end
            for (int k = 0; k < SLOTS - 1; k++)
            begin
                line_wr[k*PIXW_W + ch*PIX_W +: PIX_W] =
                    line_rd[(k+1)*PIXW_W + ch*PIX_W +: PIX_W];
            end
            line_wr[(SLOTS-1)*PIXW_W + ch*PIX_W +: PIX_W] = lane_hval[ch];
        end
    end

    // one filter lane per colour channel
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        lttf_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .take     (take),
            .en       (en),
            .pix      (s_axis_tdata[g*PIX_W +: PIX_W]),
            .h_on     (h_on),
            .line     (lane_line[g]),
            .inner    (s1_info_reg.inner),
            .hval_reg (lane_hval[g]),
            .res_reg  (lane_res[g])
        );
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= s_axis_tvalid;
            out_valid_reg <= s1_valid_reg && s1_info_reg.emit;
        end
    end

    // stage one and merge payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_info_reg  <= info;
            s1_hc_reg    <= hc;
            out_row_reg  <= s1_info_reg.orow;
            out_col_reg  <= COL_W'(s1_hc_reg);
            out_last_reg <= s1_info_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, lane_res[2], lane_res[1], lane_res[0],
                            out_col_reg, out_row_reg};

endmodule

// ===== test/tb_laws_l5r5_texture_filter_unit.sv =====
`timescale 1ns / 1ps

module tb_laws_l5r5_texture_filter_unit
    import lttf_pkg::*;
();

    localparam int MAX_W        = 1024;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 1000000;

    // one filtered pixel as it leaves the block
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             done;
    } filtered_px_t;

    typedef enum int {PAT_NOISE, PAT_STRIPES, PAT_EXTREME, PAT_FLAT} pixel_pattern_t;

    // filter predictor and store of filtered pixels still owed by the block
    class texture_scoreboard;
        bit [PIXW_W-1:0] line_rows [SLOTS][MAX_W];
        bit [PIXW_W-1:0] recent_px [4];
        int unsigned     row_pos;
        int unsigned     col_pos;
        bit [IW_W-1:0]   width_val;
        bit [IH_W-1:0]   height_val;
        filtered_px_t    expected_pixels [$];
        int              errors;
        int              requests;
        int              results;

        function new();
            row_pos = 0;
            col_pos = 0;
            width_val = IW_W'(WIDTH_RESET);
            height_val = IH_W'(HEIGHT_RESET);
            errors = 0;
            requests = 0;
            results = 0;
        endfunction

        function int unsigned cur_width();
            if (width_val < MIN_DIM) return MIN_DIM;
            if (width_val > MAX_W) return MAX_W;
            return 32'(width_val);
        endfunction

        function int unsigned cur_height();
            if (height_val < MIN_DIM) return MIN_DIM;
            if (height_val > MAX_HEIGHT) return MAX_HEIGHT;
            return 32'(height_val);
        endfunction

        function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) width_val = val[IW_W-1:0];
            else height_val = val[IH_W-1:0];
        endfunction

        // pixel requests left before the raster position wraps to the frame start
        function int unsigned to_frame_start();
            int unsigned w;
            int unsigned h;
            w = cur_width();
            h = cur_height();
            if (row_pos == 0 && col_pos == 0) return 0;
            if (row_pos + 1 >= h) return w - col_pos;
            return (h - 1 - row_pos) * w + (w - col_pos);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // accepted pixel request: advance the filter and queue any filtered pixel
        function void note_pixel(bit [PIXW_W-1:0] px);
            int unsigned     w, h, r, c, hc, orow, sum;
            int              v;
            bit [PIXW_W-1:0] hval;
            bit [PIXW_W-1:0] taps [SLOTS];
            bit [PIX_W-1:0]  mag [LANES];
            bit              emit, last, inner;
            filtered_px_t    res;
            w = cur_width();
            h = cur_height();
            r = row_pos;
            c = col_pos;
            requests++;

            // horizontal smoothing for the column two behind the request
            hval = '0;
            if (c >= 4)
            begin
                for (int ch = 0; ch < LANES; ch++)
                begin
                    sum = recent_px[0][ch*PIX_W +: PIX_W] + 4 * recent_px[1][ch*PIX_W +: PIX_W]
                        + 6 * recent_px[2][ch*PIX_W +: PIX_W]
                        + 4 * recent_px[3][ch*PIX_W +: PIX_W] + px[ch*PIX_W +: PIX_W];
                    hval[ch*PIX_W +: PIX_W] = PIX_W'(sum / 16);
                end
            end
            hc = (c >= 2) ? c - 2 : c + w - 2;

            // line stores, oldest row first
            for (int k = 0; k < SLOTS; k++) taps[k] = line_rows[k][hc];
            for (int k = 0; k < SLOTS - 1; k++) line_rows[k][hc] = taps[k+1];
            line_rows[SLOTS-1][hc] = hval;

            emit = (r >= 3) || (r == 2 && c >= 2);
            last = (r + 1 >= h) && (c + 1 >= w);

            // vertical ripple filter, zero on the border rows and columns
            if (emit)
            begin
                orow = (c >= 2) ? r - 2 : r - 3;
                inner = orow >= 2 && orow + 2 <= h - 1 && hc >= 2 && hc + 2 <= w - 1;
                for (int ch = 0; ch < LANES; ch++)
                begin
                    v = int'(taps[0][ch*PIX_W +: PIX_W]) - 4 * int'(taps[1][ch*PIX_W +: PIX_W])
                      + 6 * int'(taps[2][ch*PIX_W +: PIX_W])
                      - 4 * int'(taps[3][ch*PIX_W +: PIX_W]) + int'(hval[ch*PIX_W +: PIX_W]);
                    if (v < 0) v = -v;
                    if (v > 255) v = 255;
                    mag[ch] = inner ? v[PIX_W-1:0] : '0;
                end
                res.row = orow[ROW_W-1:0];
                res.col = hc[COL_W-1:0];
                res.red = mag[0];
                res.green = mag[1];
                res.blue = mag[2];
                res.done = last;
                expected_pixels = {expected_pixels, res};
            end

            // pixel window and raster position
            recent_px[0] = recent_px[1];
            recent_px[1] = recent_px[2];
            recent_px[2] = recent_px[3];
            recent_px[3] = px;
            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // accepted filtered pixel against the oldest one owed
        function void check_result(logic [OUT_DATA_W-1:0] d, logic tl);
            filtered_px_t want;
            if (expected_pixels.size() == 0)
            begin
                $error("filtered pixel with no request behind it: tdata %h", d);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            results++;
            compare_field("out_row", 32'(want.row), 32'(d[11:0]));
            compare_field("out_col", 32'(want.col), 32'(d[21:12]));
            compare_field("out_red", 32'(want.red), 32'(d[29:22]));
            compare_field("out_green", 32'(want.green), 32'(d[37:30]));
            compare_field("out_blue", 32'(want.blue), 32'(d[45:38]));
            compare_field("tdata padding", 0, 32'(d[47:46]));
            compare_field("frame_done", 32'(want.done), 32'(tl));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    texture_scoreboard sb;
    int                src_gap_pct;
    int                sink_gap_pct;
    int                hold_requests = 0;
    int                holds_served = 0;
    int unsigned       cycle_count;
    int                reg_writes = 0;
    int                random_px = 0;
    logic [PIXW_W-1:0] stripe_mask;
    logic [PIXW_W-1:0] base_px;

    laws_l5r5_texture_filter_unit #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, with one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d filtered pixels still owed",
               cycle_count, sb.pending());
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [PIXW_W-1:0] make_pixel(pixel_pattern_t pat);
        logic [PIXW_W-1:0] px;
        px = PIXW_W'($urandom);
        case (pat)
            PAT_STRIPES: px = ((sb.row_pos % 2) != 0) ? ~stripe_mask : stripe_mask;
            PAT_EXTREME:
            begin
                for (int ch = 0; ch < LANES; ch++)
                begin
                    case ($urandom_range(2))
                        0: px[ch*PIX_W +: PIX_W] = '0;
                        1: px[ch*PIX_W +: PIX_W] = '1;
                        default: ;
                    endcase
                end
            end
            PAT_FLAT: px = base_px ^ (PIXW_W'($urandom) & 24'h030303);
            default: ;
        endcase
        return px;
    endfunction

    // one pixel request, with random sender gaps ahead of it
    task automatic send_pixel(logic [PIXW_W-1:0] px);
        @(negedge clk);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= px;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_pixel(px);
    endtask

    task automatic send_run(int unsigned n, pixel_pattern_t pat);
        for (int unsigned i = 0; i < n; i++) send_pixel(make_pixel(pat));
    endtask

    // stop sending and wait until every filtered pixel has been taken
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // one random frame setting, started at the frame start
    task automatic random_segment();
        int unsigned       w_val, h_val, rem, k, before_cnt;
        pixel_pattern_t    pat;
        before_cnt = sb.requests;

        // idling follows the progress through the random part
        if (random_px < RANDOM_ITEMS / 3)
        begin
            src_gap_pct = 35;
            sink_gap_pct = 86;
        end
        else if (random_px < 2 * RANDOM_ITEMS / 3)
        begin
            src_gap_pct = 86;
            sink_gap_pct = 35;
        end
        else
        begin
            src_gap_pct = 0;
            sink_gap_pct = 0;
        end

        // frame shape, mostly small, sometimes clamped or with spare data bits
        case ($urandom_range(19)) inside
            [0:13]:  w_val = $urandom_range(5, 12);
            [14:16]: w_val = $urandom_range(0, 4);
            [17:18]: w_val = $urandom_range(13, 40);
            default: w_val = 13'h1800 | $urandom_range(5, 12);
        endcase
        case ($urandom_range(19)) inside
            [15:17]: h_val = $urandom_range(0, 4);
            [18:19]: h_val = $urandom_range(10, 16);
            default: h_val = $urandom_range(5, 9);
        endcase
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));

        pat = pixel_pattern_t'($urandom_range(3));
        for (int ch = 0; ch < LANES; ch++)
            stripe_mask[ch*PIX_W +: PIX_W] = $urandom_range(1) ? 8'hFF : 8'h00;
        base_px = PIXW_W'($urandom);

        rem = sb.cur_width() * sb.cur_height();
        if ($urandom_range(3) == 0)
        begin
            // height changed part way through the frame
            k = $urandom_range(1, rem - 1);
            send_run(k, pat);
            drain();
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 20)));
            send_run(sb.to_frame_start(), pat);
        end
        else
        begin
            repeat ($urandom_range(1, 2)) send_run(rem, pat);
        end
        drain();
        random_px += sb.requests - before_cnt;
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        src_gap_pct = 35;
        sink_gap_pct = 86;
        stripe_mask = '0;
        base_px = '0;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest frame via clamped values, stripes saturating both signs,
        // with a long output hold so that the input stalls
        write_reg(REG_IMAGE_WIDTH, 13'h1803);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        stripe_mask = 24'h8000FF;
        hold_requests++;
        send_run(25, PAT_STRIPES);
        drain();

        // random frames
        while (random_px < RANDOM_ITEMS) random_segment();
        repeat (20) @(posedge clk);

        $display("Covered %0d pixel requests and %0d filtered pixels with %0d register writes,",
                 sb.requests, sb.results, reg_writes);
        $display("small and clamped frame sizes, mid-frame height changes and a long output hold");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
